// ===== rtl/drf_pkg.sv =====
// Shared types and constants for the duplicate-rejecting ring FIFO.
// No dependencies; used by dedup_ring_fifo_core.
package drf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned DEPTH_DEF = 16;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // operation kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } drf_status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ,
        S_RESP
    } drf_state_t;

endpackage

// ===== rtl/drf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module drf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/dedup_ring_fifo_core.sv =====
// Top level of the duplicate-rejecting ring FIFO.
// Depends on drf_pkg (types, constants) and drf_ram (entry storage).
//
// Usage:
//   Input channel s_*: one word per operation, s_kind selects enqueue of
//   s_value or dequeue of the oldest entry. Result channel m_*: one word per
//   input word, carrying status, data, fill count and empty/full flags.
//   Both channels are valid/ready; a word moves when valid and ready are high.
//   cfg_we/cfg_wdata set the capacity in use (0 acts as 1, values above the
//   ring depth saturate) and empty the ring; write it only while idle.
// Timing:
//   One operation is in flight at a time. An enqueue walks the held entries
//   through the RAM read port, one per cycle, to check for a duplicate; a
//   match ends the walk early. A dequeue reads the oldest entry through
//   the same port; a full or empty rejection goes straight to the answer.
//   The result word shows up in the first cycle that s_ready is high again.
// Reset: aresetn (synchronous, active low) empties the ring, sets capacity
//   to 16 and drops any pending result. RAM contents are not cleared.
// Stall: a finished result sits in the output register until m_ready; the
//   sequencer holds its answer until that register frees up.
module dedup_ring_fifo_core #(
    parameter int unsigned DEPTH = drf_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [drf_pkg::CNT_W-1:0]           cfg_wdata,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic signed [drf_pkg::DATA_W-1:0]   s_value,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [drf_pkg::DATA_W-1:0]   m_data,
    output logic [drf_pkg::CNT_W-1:0]           m_fill_count,
    output logic                                m_is_empty_flag,
    output logic                                m_is_full_flag
);

    localparam int unsigned CW      = drf_pkg::CNT_W;
    localparam int unsigned DW      = drf_pkg::DATA_W;
    localparam int unsigned AW      = $clog2(DEPTH);
    // largest capacity the 5-bit register can reach on this depth
    localparam int unsigned CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam int unsigned PW      = $clog2(CAP_MAX);
    localparam logic [CW-1:0] CAP_MAX_C = CW'(CAP_MAX);

    // pointer step with wrap at the capacity in use
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p,
                                          input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= cap) ? '0 : PW'(n);
    endfunction

    // ---------------- state ----------------
    drf_pkg::drf_state_t state_reg, state_next;

    logic [CW-1:0] cap_reg,   cap_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] held_reg,  held_next;

    // scan walker
    logic [PW-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0] left_reg,     left_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [DW-1:0] val_reg,      val_next;

    // pending answer
    drf_pkg::drf_status_t res_status_reg, res_status_next;
    logic [DW-1:0]        res_data_reg,   res_data_next;
    logic [CW-1:0]        res_count_reg,  res_count_next;

    // output register
    logic          m_valid_reg,  m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [DW-1:0] m_data_reg,   m_data_next;
    logic [CW-1:0] m_count_reg,  m_count_next;
    logic          m_empty_reg,  m_empty_next;
    logic          m_full_reg,   m_full_next;

    // RAM port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_rdata;

    // ---------------- decode ----------------
    logic [CW-1:0] cap_eff;
    logic          s_fire, out_free, full_now, empty_now, scan_hit, scan_last;

    assign cap_eff   = (cap_reg == '0) ? CW'(1) :
                       ((cap_reg > CAP_MAX_C) ? CAP_MAX_C : cap_reg);
    assign s_ready   = (state_reg == drf_pkg::S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign full_now  = (held_reg >= cap_eff);
    assign empty_now = (held_reg == '0);
    assign scan_hit  = cmp_valid_reg && (ram_rdata == val_reg);
    assign scan_last = (left_reg == '0);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            drf_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (s_kind == drf_pkg::KIND_ENQ) begin
                        state_next = full_now ? drf_pkg::S_RESP : drf_pkg::S_SCAN;
                    end else begin
                        state_next = empty_now ? drf_pkg::S_RESP : drf_pkg::S_DEQ;
                    end
                end
            end
            drf_pkg::S_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = drf_pkg::S_RESP;
                end
            end
            drf_pkg::S_DEQ: begin
                state_next = drf_pkg::S_RESP;
            end
            drf_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = drf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = drf_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        cap_next        = cap_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        held_next       = held_reg;
        scan_ptr_next   = scan_ptr_reg;
        left_next       = left_reg;
        cmp_valid_next  = 1'b0;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        m_count_next    = m_count_reg;
        m_empty_next    = m_empty_reg;
        m_full_next     = m_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(wr_ptr_reg);
        ram_re          = 1'b0;
        ram_raddr       = AW'(rd_ptr_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            drf_pkg::S_IDLE: begin
                if (s_fire) begin
                    val_next = s_value;
                    if (s_kind == drf_pkg::KIND_ENQ) begin
                        res_status_next = drf_pkg::ST_FULL;
                        res_data_next   = '0;
                        res_count_next  = held_reg;
                        scan_ptr_next   = rd_ptr_reg;
                        left_next       = held_reg;
                    end else begin
                        res_status_next = drf_pkg::ST_EMPTY;
                        res_data_next   = '1;
                        res_count_next  = held_reg;
                        ram_re          = !empty_now;
                    end
                end
                // capacity write also empties the ring
                if (cfg_we) begin
                    cap_next    = cfg_wdata;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    held_next   = '0;
                end
            end
            drf_pkg::S_SCAN: begin
                if (scan_hit) begin
                    res_status_next = drf_pkg::ST_DUP;
                    res_data_next   = '0;
                    res_count_next  = held_reg;
                end else if (scan_last) begin
                    // no match among held entries: store it
                    ram_we          = 1'b1;
                    wr_ptr_next     = adv(wr_ptr_reg, cap_eff);
                    held_next       = held_reg + CW'(1);
                    res_status_next = drf_pkg::ST_DONE;
                    res_data_next   = '0;
                    res_count_next  = held_reg + CW'(1);
                end else begin
                    ram_re         = 1'b1;
                    ram_raddr      = AW'(scan_ptr_reg);
                    scan_ptr_next  = adv(scan_ptr_reg, cap_eff);
                    left_next      = left_reg - CW'(1);
                    cmp_valid_next = 1'b1;
                end
            end
            drf_pkg::S_DEQ: begin
                res_status_next = drf_pkg::ST_DONE;
                res_data_next   = ram_rdata;
                rd_ptr_next     = adv(rd_ptr_reg, cap_eff);
                held_next       = held_reg - CW'(1);
                res_count_next  = held_reg - CW'(1);
            end
            drf_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = res_data_reg;
                    m_count_next  = res_count_reg;
                    m_empty_next  = (res_count_reg == '0);
                    m_full_next   = (res_count_reg == cap_eff);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= drf_pkg::S_IDLE;
            cap_reg       <= drf_pkg::CAP_RESET;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            held_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            held_reg      <= held_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg   <= scan_ptr_next;
        left_reg       <= left_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_count_reg  <= res_count_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
        m_count_reg    <= m_count_next;
        m_empty_reg    <= m_empty_next;
        m_full_reg     <= m_full_next;
    end

    drf_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_data          = m_data_reg;
    assign m_fill_count    = m_count_reg;
    assign m_is_empty_flag = m_empty_reg;
    assign m_is_full_flag  = m_full_reg;

    // ---------------- checks ----------------
    a_held_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= cap_eff)
        else $error("held count exceeds capacity");

    a_ptrs_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW'(rd_ptr_reg) < cap_eff) && (CW'(wr_ptr_reg) < cap_eff))
        else $error("ring pointer beyond capacity");

    a_deq_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drf_pkg::S_DEQ) |-> (held_reg != '0))
        else $error("dequeue read on empty ring");

    a_store_then_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (state_reg == drf_pkg::S_RESP) && ($past(held_reg) + CW'(1) == held_reg))
        else $error("store not followed by response");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("read and write in the same scan cycle");

endmodule
